### hw/rtl/dlr_pkg.sv
// Shared constants of the DDA line rasterizer.
// No dependencies; the divider and the top level take their defaults from here.
package dlr_pkg;

   localparam int DLR_COORD_BITS    = 12;
   localparam int DLR_FRACTION_BITS = 16;

   localparam logic DLR_ACTION_LOAD = 1'b0;
   localparam logic DLR_ACTION_STEP = 1'b1;

endpackage

### hw/rtl/dlr_div.sv
// Bit-serial restoring divider: (d * 2^FRACTION_BITS) / n, truncated toward zero.
// One quotient bit per cycle through a shift register; depends on dlr_pkg for defaults.
module dlr_div #(
   parameter int COORD_BITS    = dlr_pkg::DLR_COORD_BITS,
   parameter int FRACTION_BITS = dlr_pkg::DLR_FRACTION_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [COORD_BITS-1:0]      dividend_mag,
   input  logic                       dividend_neg,
   input  logic [COORD_BITS-1:0]      divisor,
   output logic                       busy,
   output logic [FRACTION_BITS+1:0]   quotient
);

   localparam int STEPS = FRACTION_BITS + 1;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                     busy_ff, busy_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [COORD_BITS:0]      rem_ff, rem_in;
   logic [COORD_BITS-1:0]    divisor_ff, divisor_in;
   logic                     neg_ff, neg_in;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   logic [FRACTION_BITS+1:0] inc_ff, inc_in;

   logic                     fits;
   logic [COORD_BITS:0]      trial;
   logic [COORD_BITS:0]      rem_kept;
   logic [FRACTION_BITS:0]   quo_full;
   logic [FRACTION_BITS+1:0] quo_ext;

   always_comb begin
      trial    = rem_ff - {1'b0, divisor_ff};
      fits     = (rem_ff >= {1'b0, divisor_ff});
      rem_kept = fits ? trial : rem_ff;
      quo_full = {quo_ff, fits};
      quo_ext  = {1'b0, quo_full};

      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      quo_in     = quo_ff;
      inc_in     = inc_ff;

      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(STEPS);
         rem_in     = {1'b0, dividend_mag};
         divisor_in = divisor;
         neg_in     = dividend_neg;
         quo_in     = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the shifted value fits
         rem_in = {rem_kept[COORD_BITS-1:0], 1'b0};
         quo_in = quo_full[FRACTION_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            inc_in  = neg_ff ? (~quo_ext + 1'b1) : quo_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         inc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         inc_ff  <= inc_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      quo_ff     <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = inc_ff;

endmodule

### hw/rtl/dda_line_rasterizer.sv
// DDA line rasterizer top level: load/step front end, accumulators, pixel output register.
// Depends on dlr_pkg and dlr_div (one bit-serial divider per axis).
// A step's pixel is registered and appears on rsp_ in the cycle after the step transfer.
// Steps are taken one per cycle unless rsp_stall holds the output register; a load with a
// nonzero count holds req_stall while the serial dividers produce one quotient bit per cycle.
// Reset (synchronous): no line pending, increments and accumulators zero, rsp_valid low.
module dda_line_rasterizer #(
   parameter int COORD_BITS    = dlr_pkg::DLR_COORD_BITS,
   parameter int FRACTION_BITS = dlr_pkg::DLR_FRACTION_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last_pixel
);

   // accumulator: sign, integer part and fraction
   localparam int ACC_W = COORD_BITS + FRACTION_BITS + 1;
   localparam int INC_W = FRACTION_BITS + 2;

   logic signed [ACC_W-1:0]  accum_x_ff, accum_x_in;
   logic signed [ACC_W-1:0]  accum_y_ff, accum_y_in;
   logic [COORD_BITS:0]      pixels_left_ff, pixels_left_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]    rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]    rsp_y_ff, rsp_y_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     xfer;
   logic                     load_xfer;
   logic                     step_xfer;
   logic                     emit;
   logic [COORD_BITS:0]      dx, dy;
   logic [COORD_BITS-1:0]    dx_mag, dy_mag, count;
   logic                     div_start;
   logic                     busy_x, busy_y;
   logic [INC_W-1:0]         inc_x, inc_y;
   logic [COORD_BITS-1:0]    trunc_x, trunc_y;

   // Truncate an accumulator toward zero: floor, then round up negatives with a fraction.
   function automatic logic [COORD_BITS-1:0] trunc_acc(input logic [ACC_W-1:0] acc);
      logic [COORD_BITS:0] int_part;
      logic                bump;
      int_part  = acc[ACC_W-1:FRACTION_BITS];
      bump      = acc[ACC_W-1] & (|acc[FRACTION_BITS-1:0]);
      trunc_acc = COORD_BITS'(int_part + {{COORD_BITS{1'b0}}, bump});
   endfunction

   // Hold off the sender while a division runs or the output register is stuck.
   assign req_stall = busy_x | busy_y | (rsp_valid_ff & rsp_stall);
   assign xfer      = req_valid & ~req_stall;
   assign load_xfer = xfer & (req_action == dlr_pkg::DLR_ACTION_LOAD);
   assign step_xfer = xfer & (req_action == dlr_pkg::DLR_ACTION_STEP);
   // a step with no line pending drops silently
   assign emit      = step_xfer & (pixels_left_ff != '0);

   // Endpoint deltas and the pixel count max(|dx|, |dy|); |d| always fits COORD_BITS.
   always_comb begin
      logic [COORD_BITS:0] ax, ay;
      dx     = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
      dy     = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};
      ax     = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
      ay     = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
      dx_mag = ax[COORD_BITS-1:0];
      dy_mag = ay[COORD_BITS-1:0];
      count  = (dx_mag > dy_mag) ? dx_mag : dy_mag;
   end

   // A zero-length line skips the division; its increments are never used.
   assign div_start = load_xfer & (count != '0);

   dlr_div #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div_x (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .dividend_mag (dx_mag),
      .dividend_neg (dx[COORD_BITS]),
      .divisor      (count),
      .busy         (busy_x),
      .quotient     (inc_x)
   );

   dlr_div #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div_y (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .dividend_mag (dy_mag),
      .dividend_neg (dy[COORD_BITS]),
      .divisor      (count),
      .busy         (busy_y),
      .quotient     (inc_y)
   );

   assign trunc_x = trunc_acc(accum_x_ff);
   assign trunc_y = trunc_acc(accum_y_ff);

   always_comb begin
      accum_x_in     = accum_x_ff;
      accum_y_in     = accum_y_ff;
      pixels_left_in = pixels_left_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;

      if (load_xfer) begin
         // Replace any line in progress: start point in fixed point, count of pixels.
         accum_x_in     = {req_start_x[COORD_BITS-1], req_start_x, {FRACTION_BITS{1'b0}}};
         accum_y_in     = {req_start_y[COORD_BITS-1], req_start_y, {FRACTION_BITS{1'b0}}};
         pixels_left_in = {1'b0, count};
      end else if (emit) begin
         // Emit the current pixel, then advance both accumulators by one increment.
         rsp_valid_in   = 1'b1;
         rsp_x_in       = trunc_x;
         rsp_y_in       = trunc_y;
         rsp_last_in    = (pixels_left_ff == (COORD_BITS+1)'(1));
         accum_x_in     = accum_x_ff + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
         accum_y_in     = accum_y_ff + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
         pixels_left_in = pixels_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_x_ff     <= '0;
         accum_y_ff     <= '0;
         pixels_left_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         accum_x_ff     <= accum_x_in;
         accum_y_ff     <= accum_y_in;
         pixels_left_ff <= pixels_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = rsp_x_ff;
   assign rsp_pixel_y    = rsp_y_ff;
   assign rsp_last_pixel = rsp_last_ff;

endmodule
